// ===== hw/rtl/fasta_rlp_pkg.sv =====
// Shared types, codes and constants for the FASTA record layout parser.
package fasta_rlp_pkg;

  localparam int LENGTH_BITS = 40;
  localparam int LINE_BITS   = 20;
  localparam int OFFSET_BITS = 48;
  localparam int ENDS_BITS   = 8;

  localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = '1;
  localparam logic [LINE_BITS-1:0]   LINE_MAX   = '1;
  localparam logic [ENDS_BITS-1:0]   ENDS_MAX   = '1;

  localparam logic [7:0] CH_MARK  = 8'h3E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [1:0] KIND_NAME    = 2'd0;
  localparam logic [1:0] KIND_SEQ     = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NO_MARK    = 3'd1;
  localparam logic [2:0] ST_EOF_HEAD   = 3'd2;
  localparam logic [2:0] ST_MARK_FIRST = 3'd3;
  localparam logic [2:0] ST_LENGTHS    = 3'd4;
  localparam logic [2:0] ST_ENDINGS    = 3'd5;
  localparam logic [2:0] ST_NO_SEQ     = 3'd6;

  typedef enum logic [4:0] {
    PH_MARK  = 5'b00001,
    PH_HEAD  = 5'b00010,
    PH_FIRST = 5'b00100,
    PH_REST  = 5'b01000,
    PH_DONE  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [1:0]             kind;
    logic [7:0]             char_value;
    logic [2:0]             status;
    logic [LENGTH_BITS-1:0] seq_length;
    logic [LINE_BITS-1:0]   line_length;
    logic [LINE_BITS:0]     line_bytes;
    logic [OFFSET_BITS-1:0] base_offset;
  } result_t;

endpackage

// ===== hw/rtl/fasta_rlp_parse.sv =====
// Record parse state machine: per-byte state update and result generation.
module fasta_rlp_parse (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 step,
  input  logic [7:0]                           data_byte,
  input  logic                                 end_of_file,
  input  logic [fasta_rlp_pkg::OFFSET_BITS-1:0] record_offset,
  output logic                                 res_valid,
  output fasta_rlp_pkg::result_t               res
);

  fasta_rlp_pkg::phase_t                 phase, phase_next;
  logic                                  in_name, in_name_next;
  logic [fasta_rlp_pkg::OFFSET_BITS-1:0] offset_count, offset_count_next;
  logic [fasta_rlp_pkg::LENGTH_BITS-1:0] base_count, base_count_next;
  logic [fasta_rlp_pkg::LINE_BITS-1:0]   current_line, current_line_next;
  logic [fasta_rlp_pkg::ENDS_BITS-1:0]   current_ends, current_ends_next;
  logic [fasta_rlp_pkg::LINE_BITS-1:0]   first_line, first_line_next;
  logic [fasta_rlp_pkg::ENDS_BITS-1:0]   first_ends, first_ends_next;
  logic [fasta_rlp_pkg::LINE_BITS-1:0]   pending_line, pending_line_next;
  logic [1:0]                            lines_seen, lines_seen_next;
  logic                                  after_eol, after_eol_next;
  logic [2:0]                            sticky_error, sticky_error_next;

  logic       is_eol;
  logic       do_base;
  logic       do_fatal;
  logic       do_sum;
  logic [2:0] fatal_code;

  assign is_eol = (data_byte == fasta_rlp_pkg::CH_LF) || (data_byte == fasta_rlp_pkg::CH_CR);

  always_comb begin
    phase_next        = phase;
    in_name_next      = in_name;
    offset_count_next = offset_count;
    base_count_next   = base_count;
    current_line_next = current_line;
    current_ends_next = current_ends;
    first_line_next   = first_line;
    first_ends_next   = first_ends;
    pending_line_next = pending_line;
    lines_seen_next   = lines_seen;
    after_eol_next    = after_eol;
    sticky_error_next = sticky_error;
    do_base    = 1'b0;
    do_fatal   = 1'b0;
    do_sum     = 1'b0;
    fatal_code = fasta_rlp_pkg::ST_OK;
    res_valid  = 1'b0;
    res        = '0;

    if (step) begin
      case (phase)
        fasta_rlp_pkg::PH_MARK: begin
          if (end_of_file || data_byte != fasta_rlp_pkg::CH_MARK) begin
            do_fatal   = 1'b1;
            fatal_code = fasta_rlp_pkg::ST_NO_MARK;
          end else begin
            offset_count_next = record_offset + 48'd1;
            phase_next        = fasta_rlp_pkg::PH_HEAD;
          end
        end
        fasta_rlp_pkg::PH_HEAD: begin
          if (end_of_file) begin
            do_fatal   = 1'b1;
            fatal_code = fasta_rlp_pkg::ST_EOF_HEAD;
          end else begin
            offset_count_next = offset_count + 48'd1;
            if (in_name) begin
              if (data_byte <= fasta_rlp_pkg::CH_SPACE) begin
                in_name_next = 1'b0;
              end else begin
                res_valid      = 1'b1;
                res.kind       = fasta_rlp_pkg::KIND_NAME;
                res.char_value = data_byte;
              end
            end
            if (is_eol) begin
              phase_next = fasta_rlp_pkg::PH_FIRST;
            end
          end
        end
        fasta_rlp_pkg::PH_FIRST: begin
          if (end_of_file) begin
            if (current_line == '0) begin
              do_fatal   = 1'b1;
              fatal_code = fasta_rlp_pkg::ST_NO_SEQ;
            end else begin
              first_line_next = current_line;
              first_ends_next = '0;
              do_sum          = 1'b1;
            end
          end else if (is_eol) begin
            if (current_line != '0) begin
              first_line_next   = current_line;
              current_line_next = '0;
              lines_seen_next   = 2'd1;
              current_ends_next = 8'd1;
              after_eol_next    = 1'b1;
              phase_next        = fasta_rlp_pkg::PH_REST;
            end else begin
              offset_count_next = offset_count + 48'd1;
            end
          end else if (data_byte == fasta_rlp_pkg::CH_MARK) begin
            do_fatal   = 1'b1;
            fatal_code = fasta_rlp_pkg::ST_MARK_FIRST;
          end else begin
            do_base = 1'b1;
          end
        end
        fasta_rlp_pkg::PH_REST: begin
          if (end_of_file) begin
            if (after_eol && lines_seen == 2'd1) begin
              first_ends_next = current_ends;
            end
            do_sum = 1'b1;
          end else if (is_eol) begin
            if (!after_eol) begin
              pending_line_next = current_line;
              if (lines_seen != 2'd3) begin
                lines_seen_next = lines_seen + 2'd1;
              end
              current_line_next = '0;
            end
            after_eol_next = 1'b1;
            if (current_ends != fasta_rlp_pkg::ENDS_MAX) begin
              current_ends_next = current_ends + 8'd1;
            end
          end else begin
            if (after_eol) begin
              if (lines_seen == 2'd1) begin
                first_ends_next = current_ends;
              end else if (data_byte != fasta_rlp_pkg::CH_MARK &&
                           sticky_error == fasta_rlp_pkg::ST_OK) begin
                if (pending_line != first_line) begin
                  sticky_error_next = fasta_rlp_pkg::ST_LENGTHS;
                end else if (current_ends != first_ends) begin
                  sticky_error_next = fasta_rlp_pkg::ST_ENDINGS;
                end
              end
              current_ends_next = '0;
            end
            after_eol_next = 1'b0;
            if (data_byte == fasta_rlp_pkg::CH_MARK) begin
              do_sum = 1'b1;
            end else begin
              do_base = 1'b1;
            end
          end
        end
        fasta_rlp_pkg::PH_DONE: begin
        end
        default: begin
        end
      endcase
    end

    if (do_base) begin
      if (base_count != fasta_rlp_pkg::LENGTH_MAX) begin
        base_count_next = base_count + 40'd1;
      end
      if (current_line != fasta_rlp_pkg::LINE_MAX) begin
        current_line_next = current_line + 20'd1;
      end
      if (data_byte > fasta_rlp_pkg::CH_SPACE && data_byte <= fasta_rlp_pkg::CH_TILDE) begin
        res_valid      = 1'b1;
        res.kind       = fasta_rlp_pkg::KIND_SEQ;
        res.char_value = data_byte;
      end
    end

    if (do_fatal) begin
      phase_next = fasta_rlp_pkg::PH_DONE;
      res_valid  = 1'b1;
      res.kind   = fasta_rlp_pkg::KIND_SUMMARY;
      res.status = fatal_code;
    end

    if (do_sum) begin
      phase_next      = fasta_rlp_pkg::PH_DONE;
      res_valid       = 1'b1;
      res.kind        = fasta_rlp_pkg::KIND_SUMMARY;
      res.status      = sticky_error_next;
      res.seq_length  = base_count_next;
      res.line_length = first_line_next;
      res.line_bytes  = {1'b0, first_line_next} + 21'(first_ends_next);
      res.base_offset = offset_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= fasta_rlp_pkg::PH_MARK;
      in_name      <= 1'b1;
      offset_count <= '0;
      base_count   <= '0;
      current_line <= '0;
      current_ends <= '0;
      first_line   <= '0;
      first_ends   <= '0;
      pending_line <= '0;
      lines_seen   <= '0;
      after_eol    <= 1'b1;
      sticky_error <= fasta_rlp_pkg::ST_OK;
    end else begin
      phase        <= phase_next;
      in_name      <= in_name_next;
      offset_count <= offset_count_next;
      base_count   <= base_count_next;
      current_line <= current_line_next;
      current_ends <= current_ends_next;
      first_line   <= first_line_next;
      first_ends   <= first_ends_next;
      pending_line <= pending_line_next;
      lines_seen   <= lines_seen_next;
      after_eol    <= after_eol_next;
      sticky_error <= sticky_error_next;
    end
  end

endmodule

// ===== hw/rtl/fasta_rlp_out_buf.sv =====
// Result register between the parser and the master-side stream.
module fasta_rlp_out_buf (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  fasta_rlp_pkg::result_t res,
  input  logic                   take,
  output logic                   advance,
  output logic                   valid,
  output fasta_rlp_pkg::result_t res_q
);

  assign advance = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load) begin
      res_q <= res;
    end
  end

endmodule

// ===== hw/rtl/fasta_record_layout_parser.sv =====
// Top level of the FASTA record layout parser.
// Each byte is held in the input register and parsed; its result, if any, is loaded
// into the result register, which drives m_*. Throughput: one byte per cycle unless
// m_tready stalls a held result; the input register, the parse logic and the
// result register form a two-stage pipeline with a single per-byte state update.
// Reset (rst, synchronous): empties both registers, returns the parser to
// expecting the record marker and clears record_offset to zero.
module fasta_record_layout_parser (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] data_byte
  input  logic         s_tlast,   // end_of_file
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [143:0] m_tdata,   // char_value, status, seq_length, line_length,
                                  // line_bytes, first base offset, zero pad
  output logic [1:0]   m_tuser,   // [1:0] kind
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [47:0]  cfg_data   // record_offset
);

  logic [fasta_rlp_pkg::OFFSET_BITS-1:0] record_offset;
  logic                   in_valid;
  logic [7:0]             in_byte;
  logic                   in_eof;
  logic                   advance;
  logic                   step;
  logic                   res_valid;
  fasta_rlp_pkg::result_t res;
  fasta_rlp_pkg::result_t res_q;

  assign cfg_ready = 1'b1;
  assign s_tready  = !in_valid || advance;
  assign step      = in_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      record_offset <= '0;
    end else if (cfg_valid) begin
      record_offset <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_eof  <= s_tlast;
    end
  end

  fasta_rlp_parse u_parse (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .data_byte     (in_byte),
    .end_of_file   (in_eof),
    .record_offset (record_offset),
    .res_valid     (res_valid),
    .res           (res)
  );

  fasta_rlp_out_buf u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (res_valid),
    .res     (res),
    .take    (m_tready),
    .advance (advance),
    .valid   (m_tvalid),
    .res_q   (res_q)
  );

  assign m_tuser = res_q.kind;
  assign m_tdata = {4'd0, res_q.base_offset, res_q.line_bytes, res_q.line_length,
                    res_q.seq_length, res_q.status, res_q.char_value};

endmodule

// ===== hw/rtl/fasta_rlp_checker.sv =====
// Port-level checker for the FASTA record layout parser, with its bind.
module fasta_rlp_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [143:0] m_tdata,
  input logic [1:0]   m_tuser
);

  logic summary_out;
  logic fatal_status;

  assign summary_out  = m_tvalid && (m_tuser == fasta_rlp_pkg::KIND_SUMMARY);
  assign fatal_status = (m_tdata[10:8] == fasta_rlp_pkg::ST_NO_MARK) ||
                        (m_tdata[10:8] == fasta_rlp_pkg::ST_EOF_HEAD) ||
                        (m_tdata[10:8] == fasta_rlp_pkg::ST_MARK_FIRST) ||
                        (m_tdata[10:8] == fasta_rlp_pkg::ST_NO_SEQ);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_after_summary: assert property (@(posedge clk) disable iff (rst)
    summary_out && m_tready |=> !m_tvalid)
    else $error("result after record summary");

  a_byte_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != fasta_rlp_pkg::KIND_SUMMARY |-> m_tdata[143:8] == '0)
    else $error("byte result carries summary fields");

  a_fatal_zero: assert property (@(posedge clk) disable iff (rst)
    summary_out && fatal_status |-> m_tdata[143:11] == '0 && m_tdata[7:0] == 8'd0)
    else $error("fatal summary carries counts");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser != 2'd3)
    else $error("undefined result kind");

endmodule

bind fasta_record_layout_parser fasta_rlp_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
